@@ hdl/nhq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhq_pkg
// Shared codes and types for the NVMe host I/O queue pair unit.
// ----------------------------------------------------------------------------
package nhq_pkg;

  // result kinds
  localparam logic [1:0] KIND_CMD      = 2'd0;
  localparam logic [1:0] KIND_DOORBELL = 2'd1;
  localparam logic [1:0] KIND_VERDICT  = 2'd2;

  // verdict codes
  localparam logic [2:0] VERD_OK       = 3'd0;
  localparam logic [2:0] VERD_REJECT   = 3'd1;
  localparam logic [2:0] VERD_ID_MISS  = 3'd2;
  localparam logic [2:0] VERD_DEV_ERR  = 3'd3;
  localparam logic [2:0] VERD_EMPTY    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_CAPACITY  = 3'd1;
  localparam logic [2:0] REG_STRIDE    = 3'd2;
  localparam logic [2:0] REG_QUEUE_NUM = 3'd3;
  localparam logic [2:0] REG_BUF_ADDR  = 3'd4;

  // input function codes
  localparam logic FUNC_SUBMIT   = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  // work modes
  localparam logic [1:0] MODE_REJECT = 2'd0;
  localparam logic [1:0] MODE_SUBMIT = 2'd1;
  localparam logic [1:0] MODE_MATCH  = 2'd2;
  localparam logic [1:0] MODE_EMPTY  = 2'd3;

  localparam logic [31:0] DB_BASE = 32'h0000_0100;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  opcode;
    logic [31:0] nsid;
    logic [63:0] lba;
    logic [15:0] cnt_m1;
    logic [1:0]  slot;
    logic [15:0] cid;
    logic [15:0] db_value;
    logic [2:0]  verdict;
    logic [10:0] status;
  } work_t;

endpackage
`default_nettype wire

@@ hdl/nhq_admit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nhq_admit
// Submit admission check: enable, sector count limit and namespace range.
// ----------------------------------------------------------------------------
module nhq_admit #(
  parameter int MAX_SECTORS = 32
) (
  input  wire logic        enable,
  input  wire logic [63:0] capacity,
  input  wire logic [63:0] lba,
  input  wire logic [15:0] count,
  output logic             bad
);

  localparam logic [16:0] MaxCnt = 17'(MAX_SECTORS);

  logic        cnt_bad;
  logic        range_bad;
  logic [63:0] room;

  always_comb begin
    room      = capacity - lba;
    cnt_bad   = (count == 16'd0) || ({1'b0, count} > MaxCnt);
    range_bad = (capacity != 64'd0) &&
                ((lba >= capacity) || ({48'd0, count} > room));
    bad       = !enable || cnt_bad || range_bad;
  end

endmodule
`default_nettype wire

@@ hdl/nvme_host_io_queue_pair_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nvme_host_io_queue_pair_unit
// Host side of one NVMe I/O queue pair: builds command dwords and doorbell
// writes for submits, checks completions against phase and pending id.
// ----------------------------------------------------------------------------
// One result per cycle from the result sequencer unless the output stalls:
// command dwords and a doorbell write for an accepted submit, a doorbell
// write and a verdict for a matched completion, one verdict for a reject or
// an empty completion; the next input is taken as the last result is loaded.
// Synchronous active-low reset: registers to defaults, queue state cleared,
// expected phase set to one, output empty.
module nvme_host_io_queue_pair_unit #(
  parameter int QUEUE_DEPTH = 4,
  parameter int MAX_SECTORS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [7:0] command_opcode, [39:8] namespace, [103:40] start_sector,
  // [119:104] sector_count, [151:120] completion_word
  input  wire logic [151:0] in_tdata,
  // [0] func
  input  wire logic [0:0]   in_tuser,
  // results
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [3:0] word_index, [5:4] slot_index, [37:6] doorbell_offset,
  // [69:38] write_data, [72:70] verdict, [83:73] device_status, [87:84] zero
  output logic [87:0]       out_tdata,
  // [1:0] kind
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  localparam int AW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LastPtr = AW'(QUEUE_DEPTH - 1);

  // configuration registers
  logic        enable_r;
  logic [63:0] capacity_r;
  logic [3:0]  stride_r;
  logic [15:0] qnum_r;
  logic [63:0] buf_addr_r;

  // queue state
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          phase_r, phase_nxt;
  logic [15:0]   pend_r, pend_nxt;

  // sequencer
  logic                busy_r, busy_nxt;
  logic [4:0]          beat_r, beat_nxt;
  nhq_pkg::work_t      work_r, work_nxt;

  // output register
  logic        ovalid_r, ovalid_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [3:0]  owidx_r, owidx_nxt;
  logic [1:0]  oslot_r, oslot_nxt;
  logic [31:0] ooff_r, ooff_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [2:0]  overd_r, overd_nxt;
  logic [10:0] ostat_r, ostat_nxt;
  logic        olast_r, olast_nxt;

  // input fields
  logic        in_func;
  logic [7:0]  in_opcode;
  logic [31:0] in_nsid;
  logic [63:0] in_lba;
  logic [15:0] in_count;
  logic [31:0] in_cw;

  logic        bad;
  logic        adv;
  logic        final_beat;
  logic        in_acc;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] head_inc;
  logic [15:0] tail_ext;
  logic [15:0] cid;
  logic [15:0] cw_id;
  logic [10:0] cw_status;
  logic [31:0] db_idx;
  logic [4:0]  db_shamt;
  logic [31:0] db_off;
  logic [31:0] cmd_word;

  assign in_func   = in_tuser[0];
  assign in_opcode = in_tdata[7:0];
  assign in_nsid   = in_tdata[39:8];
  assign in_lba    = in_tdata[103:40];
  assign in_count  = in_tdata[119:104];
  assign in_cw     = in_tdata[151:120];

  assign cfg_ready = 1'b1;

  nhq_admit #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_admit (
    .enable   (enable_r),
    .capacity (capacity_r),
    .lba      (in_lba),
    .count    (in_count),
    .bad      (bad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      capacity_r <= '0;
      stride_r   <= '0;
      qnum_r     <= 16'd1;
      buf_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nhq_pkg::REG_ENABLE:    enable_r   <= cfg_data[0];
        nhq_pkg::REG_CAPACITY:  capacity_r <= cfg_data;
        nhq_pkg::REG_STRIDE:    stride_r   <= cfg_data[3:0];
        nhq_pkg::REG_QUEUE_NUM: qnum_r     <= cfg_data[15:0];
        nhq_pkg::REG_BUF_ADDR:  buf_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencing control
  always_comb begin
    adv = busy_r && (!ovalid_r || out_tready);
    case (work_r.mode)
      nhq_pkg::MODE_SUBMIT: final_beat = beat_r[4];
      nhq_pkg::MODE_MATCH:  final_beat = beat_r[0];
      default:              final_beat = 1'b1;
    endcase
    in_tready = !busy_r || (adv && final_beat);
    in_acc    = in_tvalid && in_tready;
  end

  // decode at accept, queue state update
  always_comb begin
    tail_inc  = (tail_r == LastPtr) ? '0 : tail_r + AW'(1);
    head_inc  = (head_r == LastPtr) ? '0 : head_r + AW'(1);
    tail_ext  = 16'(tail_r);
    cid       = tail_ext + 16'd1;
    cw_id     = in_cw[31:16];
    cw_status = in_cw[11:1];

    tail_nxt  = tail_r;
    head_nxt  = head_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;

    work_nxt          = work_r;
    work_nxt.opcode   = in_opcode;
    work_nxt.nsid     = in_nsid;
    work_nxt.lba      = in_lba;
    work_nxt.cnt_m1   = in_count - 16'd1;
    work_nxt.slot     = tail_ext[1:0];
    work_nxt.cid      = cid;
    work_nxt.db_value = '0;
    work_nxt.verdict  = nhq_pkg::VERD_OK;
    work_nxt.status   = cw_status;

    if (in_func == nhq_pkg::FUNC_SUBMIT) begin
      if (bad) begin
        work_nxt.mode    = nhq_pkg::MODE_REJECT;
        work_nxt.verdict = nhq_pkg::VERD_REJECT;
      end else begin
        work_nxt.mode     = nhq_pkg::MODE_SUBMIT;
        work_nxt.db_value = 16'(tail_inc);
      end
    end else if (in_cw[0] != phase_r) begin
      work_nxt.mode    = nhq_pkg::MODE_EMPTY;
      work_nxt.verdict = nhq_pkg::VERD_EMPTY;
    end else begin
      work_nxt.mode     = nhq_pkg::MODE_MATCH;
      work_nxt.db_value = 16'(head_inc);
      if (cw_id != pend_r) begin
        work_nxt.verdict = nhq_pkg::VERD_ID_MISS;
      end else if (cw_status != 11'd0) begin
        work_nxt.verdict = nhq_pkg::VERD_DEV_ERR;
      end
    end

    if (in_acc) begin
      if (work_nxt.mode == nhq_pkg::MODE_SUBMIT) begin
        tail_nxt = tail_inc;
        pend_nxt = cid;
      end else if (work_nxt.mode == nhq_pkg::MODE_MATCH) begin
        head_nxt = head_inc;
        if (head_inc == '0) begin
          phase_nxt = !phase_r;
        end
      end
    end

    busy_nxt = busy_r;
    beat_nxt = beat_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
      beat_nxt = '0;
    end else if (adv) begin
      if (final_beat) begin
        busy_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 5'd1;
      end
    end
  end

  // result formatting
  always_comb begin
    db_shamt = {1'b0, stride_r} + 5'd2;
    db_idx   = {15'd0, qnum_r, (work_r.mode == nhq_pkg::MODE_MATCH)};
    db_off   = nhq_pkg::DB_BASE + (db_idx << db_shamt);

    case (beat_r[3:0])
      4'd0:    cmd_word = {work_r.cid, 8'd0, work_r.opcode};
      4'd1:    cmd_word = work_r.nsid;
      4'd6:    cmd_word = buf_addr_r[31:0];
      4'd7:    cmd_word = buf_addr_r[63:32];
      4'd10:   cmd_word = work_r.lba[31:0];
      4'd11:   cmd_word = work_r.lba[63:32];
      4'd12:   cmd_word = {16'd0, work_r.cnt_m1};
      default: cmd_word = '0;
    endcase

    okind_nxt = nhq_pkg::KIND_VERDICT;
    owidx_nxt = '0;
    oslot_nxt = '0;
    ooff_nxt  = '0;
    odata_nxt = '0;
    overd_nxt = work_r.verdict;
    ostat_nxt = '0;
    olast_nxt = final_beat;

    case (work_r.mode)
      nhq_pkg::MODE_SUBMIT: begin
        if (beat_r[4]) begin
          okind_nxt = nhq_pkg::KIND_DOORBELL;
          ooff_nxt  = db_off;
          odata_nxt = {16'd0, work_r.db_value};
        end else begin
          okind_nxt = nhq_pkg::KIND_CMD;
          owidx_nxt = beat_r[3:0];
          oslot_nxt = work_r.slot;
          odata_nxt = cmd_word;
        end
        overd_nxt = nhq_pkg::VERD_OK;
      end
      nhq_pkg::MODE_MATCH: begin
        if (!beat_r[0]) begin
          okind_nxt = nhq_pkg::KIND_DOORBELL;
          ooff_nxt  = db_off;
          odata_nxt = {16'd0, work_r.db_value};
          overd_nxt = nhq_pkg::VERD_OK;
        end else begin
          ostat_nxt = work_r.status;
        end
      end
      default: ;
    endcase

    ovalid_nxt = ovalid_r;
    if (adv) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r   <= '0;
      head_r   <= '0;
      phase_r  <= 1'b1;
      pend_r   <= '0;
      busy_r   <= 1'b0;
      beat_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      tail_r   <= tail_nxt;
      head_r   <= head_nxt;
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      busy_r   <= busy_nxt;
      beat_r   <= beat_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      work_r <= work_nxt;
    end
    if (adv) begin
      okind_r <= okind_nxt;
      owidx_r <= owidx_nxt;
      oslot_r <= oslot_nxt;
      ooff_r  <= ooff_nxt;
      odata_r <= odata_nxt;
      overd_r <= overd_nxt;
      ostat_r <= ostat_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {4'd0, ostat_r, overd_r, odata_r, ooff_r, oslot_r, owidx_r};

endmodule
`default_nettype wire
